// ===== rtl/kvt_pkg.sv =====
// types, constants and helper functions of the key/value table
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int KEY_CHARS   = 8;
  localparam int VALUE_BYTES = 8;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_GET   = 2'd1,
    OP_SET   = 2'd2,
    OP_ERASE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_NOT_INIT  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_OVERFLOW  = 3'd4,
    STAT_NO_SPACE  = 3'd5
  } status_t;

  typedef struct packed {
    op_t         operation;
    logic [63:0] key;
    logic [63:0] value_in;
    logic [3:0]  value_len_in;
    logic [3:0]  capacity;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value_out;
    logic [3:0]  value_len_out;
  } rsp_t;

  // low n bytes set
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    begin
      m = '0;
      for (int b = 0; b < 8; b++) begin
        if (4'(b) < n) begin
          m[b*8 +: 8] = 8'hff;
        end
      end
      return m;
    end
  endfunction

  // key cut at its first zero byte and limited to KEY_CHARS bytes
  function automatic logic [63:0] key_norm(input logic [63:0] k);
    logic [63:0] r;
    logic        run;
    begin
      r   = '0;
      run = 1'b1;
      for (int b = 0; b < 8; b++) begin
        run = run & (k[b*8 +: 8] != 8'h00);
        if (run && (b < KEY_CHARS)) begin
          r[b*8 +: 8] = k[b*8 +: 8];
        end
      end
      return r;
    end
  endfunction

  // empty key, or a key longer than KEY_CHARS
  function automatic logic key_bad(input logic [63:0] k);
    logic run;
    begin
      run = 1'b1;
      for (int b = 0; b < 8; b++) begin
        if (b <= KEY_CHARS) begin
          run = run & (k[b*8 +: 8] != 8'h00);
        end
      end
      return (k[7:0] == 8'h00) || ((KEY_CHARS < 8) && run);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/key_value_table_core.sv =====
// key/value table with a single shared key comparator stepped over the entries
//
//  channel  direction  payload          handshake
//  req      in         kvt_pkg::req_t   req_valid / req_ready
//  rsp      out        kvt_pkg::rsp_t   rsp_valid / rsp_ready
//
//  a transaction that is decided at once (init, not ready, bad set) goes straight to the finish step;
//  otherwise the entries are scanned until the first key match or the last entry (at most 16 entries)
//  the scan uses the one key comparator, which visits one entry per cycle
//  req_ready is high only while the sequencer is idle; the result register holds
//  a finished result while the next transaction is taken
//  synchronous reset clears the valid marks, the ready flag and the result valid flag
`timescale 1ns / 1ps
`default_nettype none

module key_value_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire kvt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kvt_pkg::rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [kvt_pkg::ENTRY_COUNT-1:0] entry_valid;
  logic [63:0]                     entry_key    [kvt_pkg::ENTRY_COUNT];
  logic [63:0]                     entry_value  [kvt_pkg::ENTRY_COUNT];
  logic [3:0]                      entry_length [kvt_pkg::ENTRY_COUNT];
  logic                            ready_flag;

  kvt_pkg::op_t            op;
  logic [63:0]             nk;
  logic [63:0]             val;
  logic [3:0]              vlen;
  logic [3:0]              cap;
  logic                    decided;
  kvt_pkg::status_t        decided_status;
  logic [kvt_pkg::IDX_W-1:0] idx;
  logic                    found;
  logic [kvt_pkg::IDX_W-1:0] match_idx;
  logic                    free_found;
  logic [kvt_pkg::IDX_W-1:0] vacant_idx;
  logic [63:0]             hit_value;
  logic [3:0]              hit_len;

  logic                    accept;
  logic                    load;
  logic                    pre_done;
  kvt_pkg::status_t        pre_status;
  logic                    hit;
  logic                    last;
  kvt_pkg::status_t        fin_status;
  logic [63:0]             fin_value;
  logic [3:0]              fin_len;
  logic                    do_write;
  logic                    do_erase;
  logic [kvt_pkg::IDX_W-1:0] wr_idx;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign load      = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  assign hit       = entry_valid[idx] && (entry_key[idx] == nk);
  assign last      = (idx == kvt_pkg::IDX_W'(kvt_pkg::ENTRY_COUNT - 1));

  // checks that settle a transaction without a scan
  always_comb begin
    pre_done   = 1'b0;
    pre_status = kvt_pkg::STAT_OK;
    case (req.operation)
      kvt_pkg::OP_INIT: begin
        pre_done = 1'b1;
      end
      kvt_pkg::OP_SET: begin
        if (kvt_pkg::key_bad(req.key)) begin
          pre_done   = 1'b1;
          pre_status = kvt_pkg::STAT_INVALID;
        end else if (req.value_len_in > 4'(kvt_pkg::VALUE_BYTES)) begin
          pre_done   = 1'b1;
          pre_status = kvt_pkg::STAT_OVERFLOW;
        end else if (!ready_flag) begin
          pre_done   = 1'b1;
          pre_status = kvt_pkg::STAT_NOT_INIT;
        end
      end
      default: begin
        if (!ready_flag) begin
          pre_done   = 1'b1;
          pre_status = kvt_pkg::STAT_NOT_INIT;
        end
      end
    endcase
  end

  always_comb begin
    fin_status = kvt_pkg::STAT_OK;
    fin_value  = '0;
    fin_len    = '0;
    do_write   = 1'b0;
    do_erase   = 1'b0;
    wr_idx     = found ? match_idx : vacant_idx;
    if (decided) begin
      fin_status = decided_status;
    end else begin
      case (op)
        kvt_pkg::OP_GET: begin
          if (!found) begin
            fin_status = kvt_pkg::STAT_NOT_FOUND;
          end else if (hit_len > cap) begin
            fin_status = kvt_pkg::STAT_OVERFLOW;
          end else begin
            fin_value = hit_value;
            fin_len   = hit_len;
          end
        end
        kvt_pkg::OP_SET: begin
          if (found || free_found) begin
            do_write = 1'b1;
          end else begin
            fin_status = kvt_pkg::STAT_NO_SPACE;
          end
        end
        kvt_pkg::OP_ERASE: begin
          if (found) begin
            do_erase = 1'b1;
          end else begin
            fin_status = kvt_pkg::STAT_NOT_FOUND;
          end
        end
        default: begin
          fin_status = kvt_pkg::STAT_OK;
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      ready_flag  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.operation == kvt_pkg::OP_INIT) begin
              entry_valid <= '0;
              ready_flag  <= 1'b1;
            end
            state <= pre_done ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit || last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            if (do_write) begin
              entry_valid[wr_idx] <= 1'b1;
            end
            if (do_erase) begin
              entry_valid[match_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transaction payload and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op             <= req.operation;
      nk             <= kvt_pkg::key_norm(req.key);
      val            <= req.value_in & kvt_pkg::byte_mask(req.value_len_in);
      vlen           <= req.value_len_in;
      cap            <= req.capacity;
      decided        <= pre_done;
      decided_status <= pre_status;
      idx            <= '0;
      found          <= 1'b0;
      free_found     <= 1'b0;
    end else if (state == S_SCAN) begin
      if (hit) begin
        found     <= 1'b1;
        match_idx <= idx;
        hit_value <= entry_value[idx];
        hit_len   <= entry_length[idx];
      end
      if (!entry_valid[idx] && !free_found) begin
        free_found <= 1'b1;
        vacant_idx <= idx;
      end
      if (!last) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (load && do_write) begin
      entry_key[wr_idx]    <= nk;
      entry_value[wr_idx]  <= val;
      entry_length[wr_idx] <= vlen;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status        <= fin_status;
      rsp.value_out     <= fin_value;
      rsp.value_len_out <= fin_len;
    end
  end

`ifndef SYNTH
  a_scan_needs_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ready_flag)
    else $error("scan started before init");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == kvt_pkg::OP_INIT)) |=>
      ((state == S_FINISH) && (entry_valid == '0) && ready_flag))
    else $error("init did not clear the table");

  a_set_marks_valid: assert property (@(posedge clk) disable iff (rst)
    (load && do_write) |=> (entry_valid != '0))
    else $error("set left no valid entry");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.value_len_out != 4'd0)) |->
      ((rsp.status == kvt_pkg::STAT_OK) &&
       (rsp.value_len_out <= 4'(kvt_pkg::VALUE_BYTES))))
    else $error("value length reported outside a successful get");

  a_no_load_while_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire
